// ===== src/ale_pkg.sv =====
// ale_pkg: request and status codes, walk modes and the request plan record
// shared by the array list engine and its request planner
// no dependencies
package ale_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_DELETE     = 3'd5,
        REQ_LOCATE     = 3'd6,
        REQ_READ       = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // direction of the walk over the store
    typedef enum logic [1:0] {
        MODE_UP   = 2'd0,   // open a gap, entries move to higher indexes
        MODE_DOWN = 2'd1,   // close a gap, entries move to lower indexes
        MODE_SCAN = 2'd2,   // compare entries from the front
        MODE_READ = 2'd3    // fetch a single entry
    } t_mode;

    // where the affected slot lies
    typedef enum logic [1:0] {
        AT_ZERO  = 2'd0,
        AT_COUNT = 2'd1,
        AT_LAST  = 2'd2,
        AT_POS   = 2'd3
    } t_at;

    typedef struct packed {
        logic    walk;
        t_status status;
        t_mode   mode;
        t_at     at_sel;
    } t_plan;

endpackage

// ===== src/ale_plan.sv =====
// ale_plan: checks a request against the element count and picks the walk
// depends on ale_pkg
module ale_plan
    import ale_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  t_req                              i_req,
    input  logic [4:0]                        i_position,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]   i_count,
    output t_plan                             o_plan
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int WW = ((CW > 5) ? CW : 5) + 1;

    logic          full;
    logic          empty;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;

    assign full  = (i_count >= CW'(LIST_DEPTH));
    assign empty = (i_count == '0);
    assign pos_w = WW'(i_position);
    assign cnt_w = WW'(i_count);

    always_comb begin
        o_plan.walk   = 1'b1;
        o_plan.status = ST_OK;
        o_plan.mode   = MODE_UP;
        o_plan.at_sel = AT_ZERO;
        case (i_req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                o_plan.at_sel = (i_req == REQ_PUSH_BACK) ? AT_COUNT : AT_ZERO;
                if (full) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_FULL;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                o_plan.mode   = MODE_DOWN;
                o_plan.at_sel = (i_req == REQ_POP_FRONT) ? AT_ZERO : AT_LAST;
                if (empty) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_EMPTY;
                end
            end
            REQ_INSERT: begin
                o_plan.at_sel = AT_POS;
                if (full) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_FULL;
                end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_BADPOS;
                end
            end
            REQ_DELETE: begin
                o_plan.mode   = MODE_DOWN;
                o_plan.at_sel = AT_POS;
                if (empty) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_EMPTY;
                end else if (pos_w == '0 || pos_w > cnt_w) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_BADPOS;
                end
            end
            REQ_LOCATE: begin
                o_plan.mode = MODE_SCAN;
            end
            REQ_READ: begin
                o_plan.mode = MODE_READ;
                if (empty) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    o_plan.walk   = 1'b0;
                    o_plan.status = ST_BADPOS;
                end
            end
            default: begin
                o_plan.walk   = 1'b0;
                o_plan.status = ST_BADPOS;
            end
        endcase
    end

endmodule

// ===== src/array_list_engine_unit.sv =====
// array_list_engine_unit: top level of the array list engine, with the list
// store, the walk sequencer and the stream ports
// depends on ale_pkg and ale_plan
//
// Keeps an ordered list of signed 32-bit words in a store of LIST_DEPTH
// entries plus an element count, and answers every request transfer with
// exactly one result transfer. A request (kind in s_axis_tuser) can push at
// the back or front, pop at the front or back, insert or delete at a 1-based
// position, locate the first entry equal to a value, or read the entry at a
// 0-based index. The store is a single memory with one write and one
// registered read port, and one walker steps over it one entry a cycle: a
// shifting request moves each later entry once, a locate compares entries
// from the front until the first match. A request occupies the block from
// acceptance until its result is placed in the output register: it walks
// the touched entries through the registered read port, then waits in the
// done state for the output register; a refused request skips the walk.
// s_axis_tready is high only between requests; a result waiting in the
// output register does not hold up the next request, only the result of
// that next one. After reset the list is empty and no clearing pass is run:
// entries are only ever read below the element count.
module array_list_engine_unit
    import ale_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[4:0], data_value[36:5], zero fill
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_index[3:0], read_value[35:4],
                                        // list_count[40:36], zero fill
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    localparam int CW = $clog2(LIST_DEPTH + 1);   // element count width
    localparam int AW = $clog2(LIST_DEPTH);       // store index width

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // request fields
    t_req        in_req;
    logic [4:0]  in_pos;
    logic [31:0] in_val;
    t_plan       plan;

    // sequencer registers
    t_state        r_state;
    logic [CW-1:0] r_count;
    t_mode         r_mode;
    logic [CW-1:0] r_at;       // affected slot, receives the new value
    logic [AW-1:0] r_ptr;      // next index to read
    logic [CW-1:0] r_left;     // reads still to issue
    logic          r_pend;     // read data arrives this cycle
    logic [AW-1:0] r_pend_idx; // index that read data came from
    logic [31:0]   r_val;

    // result being built and the output register
    t_status     r_res_status;
    logic [3:0]  r_res_found;
    logic [31:0] r_res_readv;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [3:0]  r_out_found;
    logic [31:0] r_out_readv;
    logic [4:0]  r_out_count;

    // list store
    logic [31:0]   mem [LIST_DEPTH];
    logic [31:0]   r_mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;

    // values derived at acceptance
    logic [CW-1:0] acc_at;
    logic [CW-1:0] acc_left;
    logic [AW-1:0] acc_ptr;

    logic          accept;
    logic          walk_end;
    logic          match;
    logic          out_load;

    assign in_req = t_req'(s_axis_tuser);
    assign in_pos = s_axis_tdata[4:0];
    assign in_val = s_axis_tdata[36:5];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    ale_plan #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_plan (
        .i_req      (in_req),
        .i_position (in_pos),
        .i_count    (r_count),
        .o_plan     (plan)
    );

    // slot, read start and walk length for the accepted request
    always_comb begin
        case (plan.at_sel)
            AT_ZERO:  acc_at = '0;
            AT_COUNT: acc_at = r_count;
            AT_LAST:  acc_at = r_count - CW'(1);
            AT_POS:   acc_at = CW'(in_pos) - CW'(1);
            default:  acc_at = '0;
        endcase
        case (plan.mode)
            MODE_UP: begin
                acc_left = r_count - acc_at;
                acc_ptr  = AW'(r_count - CW'(1));
            end
            MODE_DOWN: begin
                acc_left = r_count - CW'(1) - acc_at;
                acc_ptr  = AW'(acc_at + CW'(1));
            end
            MODE_SCAN: begin
                acc_left = r_count;
                acc_ptr  = '0;
            end
            MODE_READ: begin
                acc_left = CW'(1);
                acc_ptr  = AW'(in_pos);
            end
            default: begin
                acc_left = '0;
                acc_ptr  = '0;
            end
        endcase
    end

    // walk finishes once every read is issued and its data has been used
    assign walk_end = (r_state == S_WALK) && !r_pend && (r_left == '0);
    assign match    = (r_state == S_WALK) && r_pend && (r_mode == MODE_SCAN)
                      && (r_mem_q == r_val);
    assign mem_re   = (r_state == S_WALK) && (r_left != '0);

    // finished result moves to the output register once that is free or draining
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // shared write port: shifted entries during the walk, new value at the end of an up walk
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_mem_q;
        if (r_state == S_WALK) begin
            if (r_pend && r_mode == MODE_UP) begin
                mem_we    = 1'b1;
                mem_waddr = r_pend_idx + AW'(1);
            end else if (r_pend && r_mode == MODE_DOWN) begin
                mem_we    = 1'b1;
                mem_waddr = r_pend_idx - AW'(1);
            end else if (walk_end && r_mode == MODE_UP) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_at);
                mem_wdata = r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[r_ptr];
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val        <= in_val;
                        r_mode       <= plan.mode;
                        r_at         <= acc_at;
                        r_ptr        <= acc_ptr;
                        r_left       <= plan.walk ? acc_left : '0;
                        r_pend       <= 1'b0;
                        r_res_status <= plan.status;
                        r_res_found  <= '0;
                        r_res_readv  <= '0;
                        r_state      <= plan.walk ? S_WALK : S_DONE;
                    end
                end
                S_WALK: begin
                    // issue the next read
                    if (r_left != '0) begin
                        r_ptr      <= (r_mode == MODE_UP) ? r_ptr - AW'(1)
                                                          : r_ptr + AW'(1);
                        r_left     <= r_left - CW'(1);
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_ptr;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // use the data read in the previous cycle
                    if (match) begin
                        r_res_status <= ST_OK;
                        r_res_found  <= 4'(r_pend_idx);
                        r_state      <= S_DONE;
                    end else if (r_pend && r_mode == MODE_READ) begin
                        r_res_readv <= r_mem_q;
                    end
                    if (walk_end) begin
                        case (r_mode)
                            MODE_UP:   r_count <= r_count + CW'(1);
                            MODE_DOWN: r_count <= r_count - CW'(1);
                            MODE_SCAN: r_res_status <= ST_NOTFOUND;
                            default:   r_count <= r_count;
                        endcase
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_status <= r_res_status;
                        r_out_found  <= r_res_found;
                        r_out_readv  <= r_res_readv;
                        r_out_count  <= 5'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_readv, r_out_found};

endmodule
